FILE: rtl/core/grib1rl_pkg.sv
// ----------------------------------------------------------------------------
// grib1rl_pkg
// Shared constants, codes and types of the GRIB1 record locator.
// ----------------------------------------------------------------------------
package grib1rl_pkg;

  localparam int WIN_LEN       = 40;
  localparam int TABLE_ENTRIES = 8;
  localparam int GRID_CAPACITY = 1024;
  localparam int QUEUE_DEPTH   = 4;

  localparam int FILL_W = $clog2(WIN_LEN + 1);
  localparam int CNT_W  = $clog2(GRID_CAPACITY + 1);
  localparam int IDX_W  = 3;
  localparam int TCNT_W = 4;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] GRIB_MARK      = 32'h4752_4942;
  localparam logic [7:0]  TR_TWO_BYTE    = 8'd10;
  localparam logic [23:0] MAX_LEN_RESET  = 24'h01_0000;

  typedef enum logic [2:0] {
    REG_GRID_ID   = 3'd0,
    REG_FORECAST  = 3'd1,
    REG_MAX_LEN   = 3'd2,
    REG_PAIRS_LO  = 3'd3,
    REG_PAIRS_HI  = 3'd4,
    REG_COUNT     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_MATCH   = 2'd0,
    KIND_ABORT   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]   grid_id;
    logic [15:0]  forecast;
    logic [23:0]  max_len;
    logic [127:0] pairs;
    logic [TCNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [23:0] length;
    logic [7:0]  param;
    logic [7:0]  ltype;
    logic [15:0] level;
    logic [TABLE_ENTRIES-1:0] mask;
    logic        len_ok;
    logic        eof;
  } rec_item_t;

  typedef struct packed {
    logic      valid;
    rec_item_t item;
  } q_head_t;

  function automatic logic [IDX_W-1:0] lowest_set(input logic [TABLE_ENTRIES-1:0] m);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/grib1rl_byte_if.sv
// ----------------------------------------------------------------------------
// grib1rl_byte_if
// Byte request channel: one file byte and its end-of-file mark.
// ----------------------------------------------------------------------------
interface grib1rl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

FILE: rtl/core/grib1rl_res_if.sv
// ----------------------------------------------------------------------------
// grib1rl_res_if
// Result request channel: match, abort and end summary results.
// ----------------------------------------------------------------------------
interface grib1rl_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] record_offset;
  logic [23:0] record_length;
  logic [7:0]  param_code;
  logic [7:0]  level_type;
  logic [15:0] level_value;
  logic [2:0]  table_index;
  logic [10:0] grids_stored;
  logic        last_of_run;

  modport source (output valid, output kind, output record_offset, output record_length,
                  output param_code, output level_type, output level_value,
                  output table_index, output grids_stored, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input record_offset, input record_length,
                  input param_code, input level_type, input level_value,
                  input table_index, input grids_stored, input last_of_run,
                  output ready);
endinterface

FILE: rtl/core/grib1rl_cfg_if.sv
// ----------------------------------------------------------------------------
// grib1rl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface grib1rl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/grib1rl_front.sv
// ----------------------------------------------------------------------------
// grib1rl_front
// Byte window and record classifier: shifts each byte into a 40-byte window,
// tests the record at the oldest byte and pushes one item per byte.
// ----------------------------------------------------------------------------
module grib1rl_front (
  input  logic                    clk,
  input  logic                    rst_n,
  grib1rl_byte_if.sink            in_port,
  input  grib1rl_pkg::cfg_t       cfg,
  input  logic                    q_full,
  output logic                    push,
  output grib1rl_pkg::rec_item_t  item
);

  logic [7:0] win_r [grib1rl_pkg::WIN_LEN];
  logic [grib1rl_pkg::FILL_W-1:0] fill_r;
  logic [grib1rl_pkg::FILL_W-1:0] fill_nxt;
  logic [31:0] pos_r;
  logic [31:0] pos_nxt;

  logic        full;
  logic        is_grib;
  logic [15:0] period;
  logic        rec_hit;
  logic [grib1rl_pkg::TCNT_W-1:0] cnt_sat;
  logic [grib1rl_pkg::TABLE_ENTRIES-1:0] mask;

  assign in_port.ready = !q_full;
  assign push          = in_port.valid && in_port.ready;

  // classify the window as it stands after this byte is shifted in
  always_comb begin
    full    = fill_r >= grib1rl_pkg::FILL_W'(grib1rl_pkg::WIN_LEN - 1);
    is_grib = {win_r[1], win_r[2], win_r[3], win_r[4]} == grib1rl_pkg::GRIB_MARK;
    period  = (win_r[29] == grib1rl_pkg::TR_TWO_BYTE) ? {win_r[27], win_r[28]}
                                                      : {8'd0, win_r[27]};
    rec_hit = full && is_grib && (win_r[15] == cfg.grid_id) && (period == cfg.forecast);
    cnt_sat = (cfg.count > grib1rl_pkg::TCNT_W'(grib1rl_pkg::TABLE_ENTRIES))
              ? grib1rl_pkg::TCNT_W'(grib1rl_pkg::TABLE_ENTRIES) : cfg.count;
    for (int i = 0; i < grib1rl_pkg::TABLE_ENTRIES; i++) begin
      mask[i] = rec_hit && (grib1rl_pkg::TCNT_W'(i) < cnt_sat)
                && (cfg.pairs[16*i+8 +: 8] == win_r[17])
                && (cfg.pairs[16*i +: 8] == win_r[18]);
    end
    item.offset = pos_r - 32'(grib1rl_pkg::WIN_LEN - 1);
    item.length = {win_r[5], win_r[6], win_r[7]};
    item.param  = win_r[17];
    item.ltype  = win_r[18];
    item.level  = {win_r[19], win_r[20]};
    item.mask   = mask;
    item.len_ok = {win_r[5], win_r[6], win_r[7]} <= cfg.max_len;
    item.eof    = in_port.end_of_file;
  end

  always_comb begin
    fill_nxt = fill_r;
    pos_nxt  = pos_r;
    if (push) begin
      if (in_port.end_of_file) begin
        fill_nxt = '0;
        pos_nxt  = '0;
      end else begin
        pos_nxt = pos_r + 32'd1;
        if (fill_r != grib1rl_pkg::FILL_W'(grib1rl_pkg::WIN_LEN)) begin
          fill_nxt = fill_r + grib1rl_pkg::FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pos_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < grib1rl_pkg::WIN_LEN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[grib1rl_pkg::WIN_LEN-1] <= in_port.data_byte;
    end
  end

endmodule

FILE: rtl/core/grib1rl_queue.sv
// ----------------------------------------------------------------------------
// grib1rl_queue
// Short item queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module grib1rl_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  grib1rl_pkg::rec_item_t  push_item,
  input  logic                    pop,
  output logic                    full,
  output grib1rl_pkg::q_head_t    head
);

  grib1rl_pkg::rec_item_t mem_r [grib1rl_pkg::QUEUE_DEPTH];
  logic [grib1rl_pkg::PTR_W-1:0]  wr_ptr_r;
  logic [grib1rl_pkg::PTR_W-1:0]  wr_ptr_nxt;
  logic [grib1rl_pkg::PTR_W-1:0]  rd_ptr_r;
  logic [grib1rl_pkg::PTR_W-1:0]  rd_ptr_nxt;
  logic [grib1rl_pkg::QCNT_W-1:0] count_r;
  logic [grib1rl_pkg::QCNT_W-1:0] count_nxt;
  logic do_pop;

  assign full       = count_r == grib1rl_pkg::QCNT_W'(grib1rl_pkg::QUEUE_DEPTH);
  assign head.valid = count_r != '0;
  assign head.item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == grib1rl_pkg::PTR_W'(grib1rl_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_r + grib1rl_pkg::PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == grib1rl_pkg::PTR_W'(grib1rl_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_r + grib1rl_pkg::PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + grib1rl_pkg::QCNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - grib1rl_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/core/grib1rl_back.sv
// ----------------------------------------------------------------------------
// grib1rl_back
// Result sequencer: walks the matched table entries of each item, keeps the
// stored count and abort flag, and holds results in an output register.
// ----------------------------------------------------------------------------
module grib1rl_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  grib1rl_pkg::q_head_t  head,
  output logic                  pop,
  grib1rl_res_if.source         out_port
);

  logic [grib1rl_pkg::CNT_W-1:0] stored_r;
  logic [grib1rl_pkg::CNT_W-1:0] stored_nxt;
  logic aborted_r;
  logic aborted_nxt;
  logic started_r;
  logic started_nxt;
  logic [grib1rl_pkg::TABLE_ENTRIES-1:0] pend_r;
  logic [grib1rl_pkg::TABLE_ENTRIES-1:0] pend_nxt;

  logic [grib1rl_pkg::TABLE_ENTRIES-1:0] eff;
  logic [grib1rl_pkg::TABLE_ENTRIES-1:0] rem;
  logic [grib1rl_pkg::IDX_W-1:0] sel;
  logic cap_hit;
  logic slot_free;
  logic load_out;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [1:0]  kind_nxt;
  logic [31:0] offset_r;
  logic [31:0] offset_nxt;
  logic [23:0] length_r;
  logic [23:0] length_nxt;
  logic [7:0]  param_r;
  logic [7:0]  param_nxt;
  logic [7:0]  ltype_r;
  logic [7:0]  ltype_nxt;
  logic [15:0] level_r;
  logic [15:0] level_nxt;
  logic [grib1rl_pkg::IDX_W-1:0] index_r;
  logic [grib1rl_pkg::IDX_W-1:0] index_nxt;
  logic [grib1rl_pkg::CNT_W-1:0] grids_r;
  logic [grib1rl_pkg::CNT_W-1:0] grids_nxt;
  logic        last_r;
  logic        last_nxt;

  assign eff       = started_r ? pend_r : head.item.mask;
  assign sel       = grib1rl_pkg::lowest_set(eff);
  assign rem       = eff & ~(grib1rl_pkg::TABLE_ENTRIES'(1) << sel);
  assign cap_hit   = stored_r >= grib1rl_pkg::CNT_W'(grib1rl_pkg::GRID_CAPACITY);
  assign slot_free = !out_valid_r || out_port.ready;

  always_comb begin
    pop         = 1'b0;
    load_out    = 1'b0;
    stored_nxt  = stored_r;
    aborted_nxt = aborted_r;
    started_nxt = started_r;
    pend_nxt    = pend_r;
    kind_nxt    = grib1rl_pkg::KIND_MATCH;
    offset_nxt  = head.item.offset;
    length_nxt  = head.item.length;
    param_nxt   = head.item.param;
    ltype_nxt   = head.item.ltype;
    level_nxt   = head.item.level;
    index_nxt   = sel;
    grids_nxt   = stored_r;
    last_nxt    = 1'b0;
    if (head.valid) begin
      if (aborted_r) begin
        // drop bytes until the end of the file re-arms the scan
        pop = 1'b1;
        if (head.item.eof) begin
          aborted_nxt = 1'b0;
          stored_nxt  = '0;
        end
      end else if ((eff != '0) && (head.item.len_ok || cap_hit)) begin
        if (slot_free) begin
          load_out = 1'b1;
          if (cap_hit) begin
            kind_nxt    = grib1rl_pkg::KIND_ABORT;
            last_nxt    = 1'b1;
            aborted_nxt = 1'b1;
            started_nxt = 1'b0;
            pop         = 1'b1;
          end else begin
            stored_nxt = stored_r + grib1rl_pkg::CNT_W'(1);
            grids_nxt  = stored_r + grib1rl_pkg::CNT_W'(1);
            last_nxt   = (rem == '0) && !head.item.eof;
            if ((rem == '0) && !head.item.eof) begin
              pop         = 1'b1;
              started_nxt = 1'b0;
            end else begin
              started_nxt = 1'b1;
              pend_nxt    = rem;
            end
          end
        end
      end else if (head.item.eof) begin
        if (slot_free) begin
          load_out    = 1'b1;
          kind_nxt    = grib1rl_pkg::KIND_SUMMARY;
          offset_nxt  = '0;
          length_nxt  = '0;
          param_nxt   = '0;
          ltype_nxt   = '0;
          level_nxt   = '0;
          index_nxt   = '0;
          last_nxt    = 1'b1;
          stored_nxt  = '0;
          started_nxt = 1'b0;
          pop         = 1'b1;
        end
      end else begin
        pop         = 1'b1;
        started_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r    <= '0;
      aborted_r   <= 1'b0;
      started_r   <= 1'b0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stored_r    <= stored_nxt;
      aborted_r   <= aborted_nxt;
      started_r   <= started_nxt;
      pend_r      <= pend_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_port.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind_r   <= kind_nxt;
      offset_r <= offset_nxt;
      length_r <= length_nxt;
      param_r  <= param_nxt;
      ltype_r  <= ltype_nxt;
      level_r  <= level_nxt;
      index_r  <= index_nxt;
      grids_r  <= grids_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_port.valid         = out_valid_r;
  assign out_port.kind          = kind_r;
  assign out_port.record_offset = offset_r;
  assign out_port.record_length = length_r;
  assign out_port.param_code    = param_r;
  assign out_port.level_type    = ltype_r;
  assign out_port.level_value   = level_r;
  assign out_port.table_index   = index_r;
  assign out_port.grids_stored  = grids_r;
  assign out_port.last_of_run   = last_r;

endmodule

FILE: rtl/core/grib1_record_locator.sv
// ----------------------------------------------------------------------------
// grib1_record_locator
// Path: each byte's item is queued, then sequenced into the output register.
// Throughput: one byte per cycle while the four-entry item queue is not full;
//   a byte causing n results holds the result sequencer until all are loaded.
// Reset: synchronous active-low rst_n clears window fill, offset, stored count,
//   abort flag, queue and registers; max_record_length resets to 65536.
// ----------------------------------------------------------------------------
module grib1_record_locator (
  input  logic          clk,
  input  logic          rst_n,
  grib1rl_byte_if.sink  in_if,
  grib1rl_res_if.source out_if,
  grib1rl_cfg_if.sink   cfg_if
);

  grib1rl_pkg::cfg_t      cfg_r;
  grib1rl_pkg::rec_item_t item;
  grib1rl_pkg::q_head_t   head;
  logic push;
  logic pop;
  logic q_full;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_id  <= '0;
      cfg_r.forecast <= '0;
      cfg_r.max_len  <= grib1rl_pkg::MAX_LEN_RESET;
      cfg_r.pairs    <= '0;
      cfg_r.count    <= '0;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (grib1rl_pkg::reg_idx_t'(cfg_if.index))
        grib1rl_pkg::REG_GRID_ID:  cfg_r.grid_id        <= cfg_if.data[7:0];
        grib1rl_pkg::REG_FORECAST: cfg_r.forecast       <= cfg_if.data[15:0];
        grib1rl_pkg::REG_MAX_LEN:  cfg_r.max_len        <= cfg_if.data[23:0];
        grib1rl_pkg::REG_PAIRS_LO: cfg_r.pairs[63:0]    <= cfg_if.data;
        grib1rl_pkg::REG_PAIRS_HI: cfg_r.pairs[127:64]  <= cfg_if.data;
        grib1rl_pkg::REG_COUNT:    cfg_r.count          <= cfg_if.data[3:0];
        default: begin
        end
      endcase
    end
  end

  grib1rl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_port (in_if),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .push    (push),
    .item    (item)
  );

  grib1rl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (item),
    .pop       (pop),
    .full      (q_full),
    .head      (head)
  );

  grib1rl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_port (out_if)
  );

  a_abort_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.kind == grib1rl_pkg::KIND_ABORT) |-> out_if.last_of_run)
    else $error("abort result not last of its run");

  a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.kind == grib1rl_pkg::KIND_SUMMARY)
      |-> out_if.last_of_run && (out_if.record_offset == '0) && (out_if.table_index == '0))
    else $error("summary result carries record fields");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.grids_stored <= 11'(grib1rl_pkg::GRID_CAPACITY)))
    else $error("stored count beyond capacity");

  a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.kind == grib1rl_pkg::KIND_MATCH) |-> (out_if.grids_stored != '0))
    else $error("match result with zero stored count");

endmodule
